>>> hdl/hashed_slot_table_with_collision_stats_macros.svh
// assertion macros for the hashed slot table
`ifndef HASHED_SLOT_TABLE_WITH_COLLISION_STATS_MACROS_SVH
`define HASHED_SLOT_TABLE_WITH_COLLISION_STATS_MACROS_SVH

// same-cycle implication, checked outside reset
`define HST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hst_pkg.sv
// shared types and constants of the hashed slot table
`timescale 1ns / 1ps

package hst_pkg;

    localparam int DEF_SLOTS      = 128;
    localparam int DEF_COUNT_BITS = 16;

    localparam int HASH_W   = 32;
    localparam int SIZE_W   = 8;
    localparam int DIV_STEPS = HASH_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0] ADD_OFFSET  = 32'd96;
    localparam logic [HASH_W-1:0] DJB2_START  = 32'd5381;
    localparam int                DJB2_SHIFT  = 5;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 8'd100;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;
    localparam logic HASH_ADD    = 1'b0;
    localparam logic HASH_DJB2   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              hash_select;
        logic [7:0]        key_char;
        logic              last_char;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [6:0]         slot_index;
        logic               stored_new;
        logic               collided;
        logic [15:0]        slot_collisions;
        logic [7:0]         filled_count;
        logic               found;
        logic signed [31:0] read_value;
    } t_out;

    // status from the slot table to the control
    typedef struct packed {
        logic done;
        logic stored_new;
        logic collided;
        logic found;
        logic clearing;
    } t_tbl_stat;

endpackage

>>> hdl/hst_hash.sv
// running additive and djb2 hash accumulators
`timescale 1ns / 1ps

module hst_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_last,
    input  logic [7:0]                 i_char,
    output logic [hst_pkg::HASH_W-1:0] o_add_next,
    output logic [hst_pkg::HASH_W-1:0] o_djb_next
);

    logic [hst_pkg::HASH_W-1:0] r_add;
    logic [hst_pkg::HASH_W-1:0] r_djb;
    logic [hst_pkg::HASH_W-1:0] w_sx;

    // byte is signed for the additive hash, unsigned for djb2
    assign w_sx       = {{(hst_pkg::HASH_W-8){i_char[7]}}, i_char};
    assign o_add_next = r_add + w_sx - hst_pkg::ADD_OFFSET;
    assign o_djb_next = (r_djb << hst_pkg::DJB2_SHIFT) + r_djb
                        + {{(hst_pkg::HASH_W-8){1'b0}}, i_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add <= '0;
            r_djb <= hst_pkg::DJB2_START;
        end else if (i_step) begin
            if (i_last) begin
                r_add <= '0;
                r_djb <= hst_pkg::DJB2_START;
            end else begin
                r_add <= o_add_next;
                r_djb <= o_djb_next;
            end
        end
    end

endmodule

>>> hdl/hst_divider.sv
// bit-serial remainder of a 32-bit hash by the table size
`timescale 1ns / 1ps

module hst_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hst_pkg::HASH_W-1:0] i_dividend,
    input  logic [hst_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [hst_pkg::SIZE_W-1:0] o_rem
);

    logic                       r_busy;
    logic                       r_done;
    logic [hst_pkg::STEP_W-1:0] r_cnt;
    logic [hst_pkg::HASH_W-1:0] r_dvd;
    logic [hst_pkg::SIZE_W-1:0] r_dvs;
    logic [hst_pkg::SIZE_W-1:0] r_rem;
    logic [hst_pkg::SIZE_W:0]   w_sh;
    logic [hst_pkg::SIZE_W+1:0] w_trial;
    logic [hst_pkg::SIZE_W-1:0] n_rem;

    // restoring step: shifted remainder stays below twice the divisor
    assign w_sh    = {r_rem, r_dvd[hst_pkg::HASH_W-1]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_dvs};
    assign n_rem   = w_trial[hst_pkg::SIZE_W+1] ? w_sh[hst_pkg::SIZE_W-1:0]
                                               : w_trial[hst_pkg::SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hst_pkg::STEP_W'(hst_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[hst_pkg::HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hdl/hst_table.sv
// slot memory with clearing sweep, read of one slot for a lookup and read-modify-write for an insert
`timescale 1ns / 1ps

module hst_table #(
    parameter int SLOTS      = hst_pkg::DEF_SLOTS,
    parameter int COUNT_BITS = hst_pkg::DEF_COUNT_BITS,
    localparam int IDX_W     = $clog2(SLOTS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [IDX_W-1:0]       i_idx,
    input  logic                   i_kind,
    input  logic signed [31:0]     i_value,
    output hst_pkg::t_tbl_stat     o_stat,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic signed [31:0]     o_rd_value
);

    localparam int ENTRY_W = 1 + 32 + COUNT_BITS;

    logic [ENTRY_W-1:0]    mem [SLOTS];
    logic [ENTRY_W-1:0]    r_rd_data;

    logic                  r_clearing;
    logic [IDX_W-1:0]      r_clr_addr;
    logic                  r_upd;
    logic                  r_kind;
    logic [IDX_W-1:0]      r_idx;
    logic signed [31:0]    r_val;

    logic                  r_done;
    logic                  r_new;
    logic                  r_col;
    logic                  r_found;
    logic [COUNT_BITS-1:0] r_cnt_out;
    logic signed [31:0]    r_val_out;

    logic                  w_occ;
    logic [31:0]           w_val;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic                  w_ins;
    logic                  w_we;
    logic [IDX_W-1:0]      w_wa;
    logic [ENTRY_W-1:0]    w_wd;

    assign w_occ     = r_rd_data[ENTRY_W-1];
    assign w_val     = r_rd_data[COUNT_BITS+31:COUNT_BITS];
    assign w_cnt     = r_rd_data[COUNT_BITS-1:0];
    assign w_cnt_inc = (w_cnt == {COUNT_BITS{1'b1}}) ? w_cnt : w_cnt + COUNT_BITS'(1);
    assign w_ins     = (r_kind == hst_pkg::KIND_INSERT);

    // sweep after reset has priority; no item is started while it runs
    assign w_we = r_clearing || (r_upd && w_ins);
    assign w_wa = r_clearing ? r_clr_addr : r_idx;
    always_comb begin
        if (r_clearing) begin
            w_wd = '0;
        end else if (w_occ) begin
            w_wd = {1'b1, w_val, w_cnt_inc};
        end else begin
            w_wd = {1'b1, r_val, w_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_upd      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_upd  <= i_start;
            r_done <= r_upd;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(SLOTS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kind <= i_kind;
            r_idx  <= i_idx;
            r_val  <= i_value;
        end
        if (r_upd) begin
            r_new     <= w_ins && !w_occ;
            r_col     <= w_ins && w_occ;
            r_found   <= !w_ins && w_occ;
            r_cnt_out <= (w_ins && w_occ) ? w_cnt_inc : w_cnt;
            r_val_out <= (!w_ins && w_occ) ? w_val : '0;
        end
    end

    assign o_stat.done       = r_done;
    assign o_stat.stored_new = r_new;
    assign o_stat.collided   = r_col;
    assign o_stat.found      = r_found;
    assign o_stat.clearing   = r_clearing;
    assign o_count           = r_cnt_out;
    assign o_rd_value        = r_val_out;

endmodule

>>> hdl/hashed_slot_table_with_collision_stats.sv
// top level of the hashed slot table with collision counts
//
// input channel i_in_valid / o_in_stall carries one key byte per beat; the
// beat with last_char set ends the key and carries kind, hash_select, value.
// output channel o_out_valid / i_out_stall carries one result beat per key.
// non-final bytes are taken one per cycle outside the clearing sweep, also
// while a key is in flight. a final byte starts a bit-serial remainder of
// the hash by the table size, then one read and, for an insert, one write
// of the slot memory; the result then moves into the output register once
// that register is free. the next final byte is held off until the result
// has moved there; bytes before it overlap with the previous key.
// i_cfg_we / i_cfg_data writes table_size; the user must write it only
// while no key is in flight, the block itself does not enforce this.
// reset (i_rst_n low, synchronous) sets table_size to 100, restarts both
// hashes and starts a clearing sweep over all SLOTS entries of the slot
// memory; o_in_stall stays high during the sweep.
// while i_out_stall is high a finished result stays in the output register
// and the block keeps taking bytes up to the next final byte.
`timescale 1ns / 1ps
`include "hashed_slot_table_with_collision_stats_macros.svh"

module hashed_slot_table_with_collision_stats #(
    parameter int SLOTS      = hst_pkg::DEF_SLOTS,
    parameter int COUNT_BITS = hst_pkg::DEF_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  hst_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output hst_pkg::t_out              o_out,
    input  logic                       i_cfg_we,
    input  logic [hst_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_TBL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [hst_pkg::SIZE_W-1:0]   r_table_size;
    logic [hst_pkg::SIZE_W-1:0]   w_size;
    logic [FILL_W-1:0]            r_filled;
    logic                         r_kind;
    logic signed [31:0]           r_value;
    logic [IDX_W-1:0]             r_idx;
    hst_pkg::t_out                r_res;
    hst_pkg::t_out                r_out;
    logic                         r_out_valid;

    logic                         w_in_acc;
    logic                         w_key_end;
    logic [hst_pkg::HASH_W-1:0]   w_add_next;
    logic [hst_pkg::HASH_W-1:0]   w_djb_next;
    logic [hst_pkg::HASH_W-1:0]   w_hash;
    logic                         w_div_done;
    logic [hst_pkg::SIZE_W-1:0]   w_div_rem;
    logic                         w_tbl_start;
    hst_pkg::t_tbl_stat           w_stat;
    logic [COUNT_BITS-1:0]        w_count;
    logic signed [31:0]           w_rd_value;
    logic                         w_out_load;

    assign o_in_stall  = w_stat.clearing || (i_in.last_char && (r_state != S_IDLE));
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_key_end   = w_in_acc && i_in.last_char;

    // lookups always take the additive hash
    assign w_hash = ((i_in.kind == hst_pkg::KIND_INSERT) &&
                     (i_in.hash_select == hst_pkg::HASH_DJB2)) ? w_djb_next : w_add_next;

    // zero behaves as one, anything past the memory depth is clamped
    always_comb begin
        if (r_table_size == '0) begin
            w_size = hst_pkg::SIZE_W'(1);
        end else if (32'(r_table_size) > 32'(SLOTS)) begin
            w_size = hst_pkg::SIZE_W'(SLOTS);
        end else begin
            w_size = r_table_size;
        end
    end

    assign w_tbl_start = (r_state == S_DIV) && w_div_done;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    hst_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_in_acc),
        .i_last     (i_in.last_char),
        .i_char     (i_in.key_char),
        .o_add_next (w_add_next),
        .o_djb_next (w_djb_next)
    );

    hst_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_key_end),
        .i_dividend (w_hash),
        .i_divisor  (w_size),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    hst_table #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_tbl_start),
        .i_idx      (IDX_W'(w_div_rem)),
        .i_kind     (r_kind),
        .i_value    (r_value),
        .o_stat     (w_stat),
        .o_count    (w_count),
        .o_rd_value (w_rd_value)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_key_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_TBL;
                end
            end
            S_TBL: begin
                if (w_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= hst_pkg::TABLE_SIZE_RESET;
            r_filled     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
            if (w_stat.done && w_stat.stored_new) begin
                r_filled <= r_filled + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_end) begin
            r_kind  <= i_in.kind;
            r_value <= i_in.value;
        end
        if (w_tbl_start) begin
            r_idx <= IDX_W'(w_div_rem);
        end
        if ((r_state == S_TBL) && w_stat.done) begin
            r_res.slot_index      <= 7'(r_idx);
            r_res.stored_new      <= w_stat.stored_new;
            r_res.collided        <= w_stat.collided;
            r_res.slot_collisions <= 16'(w_count);
            r_res.filled_count    <= 8'(w_stat.stored_new ? r_filled + 1'b1 : r_filled);
            r_res.found           <= w_stat.found;
            r_res.read_value      <= w_rd_value;
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `HST_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == S_DIV, "divider done outside divide state")
    `HST_ASSERT_NOW(a_tbl_done_in_tbl, w_stat.done, r_state == S_TBL, "table done outside table state")
    `HST_ASSERT_NOW(a_new_xor_col, w_stat.done, !(w_stat.stored_new && w_stat.collided), "slot both new and collided")
    `HST_ASSERT_NEXT(a_tbl_start_done, w_tbl_start, !w_stat.done, "table answered too early")

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the hashed slot table with collision counts
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE = 48;
    localparam int LIMIT  = 400000;
    localparam int MAX_KEY = 12;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    hst_pkg::t_in  in_beat = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    hst_pkg::t_out out_beat;
    logic          cfg_we = 1'b0;
    logic [7:0]    cfg_data = '0;

    hashed_slot_table_with_collision_stats dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the table state
    logic [7:0]  size_shadow = hst_pkg::TABLE_SIZE_RESET;
    logic [31:0] sum_hash = '0;
    logic [31:0] mul_hash = hst_pkg::DJB2_START;
    logic        slot_full [0:hst_pkg::DEF_SLOTS-1];
    logic [31:0] slot_data [0:hst_pkg::DEF_SLOTS-1];
    logic [15:0] slot_hits [0:hst_pkg::DEF_SLOTS-1];
    logic [7:0]  filled_slots = '0;

    hst_pkg::t_in  byte_queue [$];
    hst_pkg::t_out pending_results [$];

    int   mismatches = 0;
    int   bytes_sent = 0;
    int unsigned cycles = 0;

    logic [7:0] key_buf [0:MAX_KEY-1];
    int         pool_len [0:7];
    logic [7:0] pool_key [0:7][0:MAX_KEY-1];
    logic [7:0] size_plan [0:6] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd13, 8'd2, 8'd64};

    initial begin
        for (int s = 0; s < hst_pkg::DEF_SLOTS; s++) begin
            slot_full[s] = 1'b0;
            slot_data[s] = '0;
            slot_hits[s] = '0;
        end
    end

    task automatic predict_slot_result(input hst_pkg::t_in b);
        logic [31:0] hash;
        logic [31:0] modulus;
        logic [31:0] idx;
        logic [6:0]  slot;
        hst_pkg::t_out r;
        sum_hash = sum_hash + {{24{b.key_char[7]}}, b.key_char} - hst_pkg::ADD_OFFSET;
        mul_hash = (mul_hash << hst_pkg::DJB2_SHIFT) + mul_hash + {24'd0, b.key_char};
        if (!b.last_char) return;
        hash = (b.kind == hst_pkg::KIND_INSERT && b.hash_select == hst_pkg::HASH_DJB2)
               ? mul_hash : sum_hash;
        sum_hash = '0;
        mul_hash = hst_pkg::DJB2_START;
        if (size_shadow == 0)
            modulus = 1;
        else if (size_shadow > hst_pkg::DEF_SLOTS)
            modulus = hst_pkg::DEF_SLOTS;
        else
            modulus = {24'd0, size_shadow};
        idx = hash % modulus;
        slot = idx[6:0];
        r = '0;
        r.slot_index = slot;
        if (b.kind == hst_pkg::KIND_INSERT) begin
            if (!slot_full[slot]) begin
                slot_full[slot] = 1'b1;
                slot_data[slot] = b.value;
                filled_slots = filled_slots + 8'd1;
                r.stored_new = 1'b1;
            end else begin
                if (slot_hits[slot] != '1) slot_hits[slot] = slot_hits[slot] + 16'd1;
                r.collided = 1'b1;
            end
        end else if (slot_full[slot]) begin
            r.found = 1'b1;
            r.read_value = slot_data[slot];
        end
        r.slot_collisions = slot_hits[slot];
        r.filled_count = filled_slots;
        pending_results.push_back(r);
    endtask

    function automatic int pause_len(input bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // input driver
    bit in_burst = 1'b0;
    int in_gap = 0;
    always @(posedge clk) begin : driver
        int g;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (in_valid && !in_stall) begin
            predict_slot_result(in_beat);
            if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
            g = pause_len(in_burst);
            if (g == 0 && byte_queue.size() != 0) begin
                in_beat <= byte_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
                in_gap <= g;
            end
        end else if (!in_valid) begin
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
            end else if (byte_queue.size() != 0) begin
                in_beat <= byte_queue.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", name, want, got);
        end
    endtask

    // result monitor
    bit out_burst = 1'b0;
    int out_hold = 0;
    always @(posedge clk) begin : monitor
        hst_pkg::t_out want;
        int n;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold <= 0;
        end else if (out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", out_beat);
            end else begin
                want = pending_results.pop_front();
                check_field("slot_index", 32'(want.slot_index), 32'(out_beat.slot_index));
                check_field("stored_new", 32'(want.stored_new), 32'(out_beat.stored_new));
                check_field("collided", 32'(want.collided), 32'(out_beat.collided));
                check_field("slot_collisions", 32'(want.slot_collisions),
                            32'(out_beat.slot_collisions));
                check_field("filled_count", 32'(want.filled_count),
                            32'(out_beat.filled_count));
                check_field("found", 32'(want.found), 32'(out_beat.found));
                check_field("read_value", want.read_value, out_beat.read_value);
            end
            if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
            n = pause_len(out_burst);
            out_hold <= n;
            out_stall <= (n != 0);
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            out_stall <= (out_hold > 1);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // queue one key from key_buf; only the final beat's kind, select and value count
    task automatic send_key(input logic kind, input logic sel, input int len,
                            input logic [31:0] val);
        hst_pkg::t_in b;
        for (int j = 0; j < len; j++) begin
            b.key_char = key_buf[j];
            b.last_char = (j == len - 1);
            b.kind = b.last_char ? kind : logic'($urandom % 2);
            b.hash_select = b.last_char ? sel : logic'($urandom % 2);
            b.value = b.last_char ? val : $urandom;
            byte_queue.push_back(b);
        end
        bytes_sent += len;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        size_shadow = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly keys from a small pool so lookups find earlier inserts
    task automatic run_random(input int n_bytes);
        int first;
        int r;
        int p;
        int len;
        first = bytes_sent;
        for (int q = 0; q < 8; q++) begin
            pool_len[q] = $urandom_range(1, 4);
            for (int j = 0; j < MAX_KEY; j++) pool_key[q][j] = 8'($urandom);
        end
        while (bytes_sent - first < n_bytes) begin
            r = $urandom_range(0, 9);
            p = $urandom_range(0, 7);
            if (r <= 7) begin
                len = pool_len[p];
                for (int j = 0; j < len; j++) key_buf[j] = pool_key[p][j];
            end else begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_KEY)
                                                  : $urandom_range(1, 3);
                for (int j = 0; j < len; j++) key_buf[j] = 8'($urandom);
            end
            if (r <= 3)
                send_key(hst_pkg::KIND_INSERT, logic'($urandom % 2), len, $urandom);
            else if (r <= 6)
                send_key(hst_pkg::KIND_LOOKUP, logic'($urandom % 2), len, $urandom);
            else
                send_key(logic'($urandom % 2), logic'($urandom % 2), len, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed keys at the reset table size
        key_buf[0] = 8'h00;
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_ADD, 1, 32'h7fff_ffff);
        key_buf[0] = 8'hff;
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_DJB2, 1, 32'h8000_0000);
        key_buf[0] = 8'h00;
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_ADD, 1, 32'h1234_5678);   // same slot again
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_DJB2, 1, 32'hffff_ffff);
        send_key(hst_pkg::KIND_LOOKUP, hst_pkg::HASH_DJB2, 1, 32'h0);  // lookup ignores select
        key_buf[0] = 8'h7f;
        send_key(hst_pkg::KIND_LOOKUP, hst_pkg::HASH_ADD, 1, 32'h0);           // empty slot
        key_buf[0] = 8'h80;
        send_key(hst_pkg::KIND_LOOKUP, hst_pkg::HASH_ADD, 1, 32'h0);
        key_buf[0] = 8'h60;                                  // additive hash of zero
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_ADD, 1, 32'h0000_0000);
        send_key(hst_pkg::KIND_LOOKUP, hst_pkg::HASH_ADD, 1, 32'hffff_ffff);
        key_buf[0] = 8'h41; key_buf[1] = 8'h42; key_buf[2] = 8'h43;
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_ADD, 3, 32'hdead_beef);
        send_key(hst_pkg::KIND_LOOKUP, hst_pkg::HASH_ADD, 3, 32'h0);
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_DJB2, 3, 32'h5555_aaaa);
        for (int j = 0; j < 8; j++) key_buf[j] = 8'hff;
        send_key(hst_pkg::KIND_INSERT, hst_pkg::HASH_DJB2, 8, 32'haaaa_5555);
        run_random(60);
        wait_idle();

        for (int k = 0; k < 7; k++) begin
            write_size(size_plan[k]);
            run_random(55);
            wait_idle();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hst_pkg.sv
hdl/hst_hash.sv
hdl/hst_divider.sv
hdl/hst_table.sv
hdl/hashed_slot_table_with_collision_stats.sv
tb/sv/tb.sv
